/* sv/fsps_pkg.sv */
// ----------------------------------------------------------------------------
// fsps_pkg: shared types and constants of the frame sad peak selector
// Payload structs for both streaming channels, the register map and the
// fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package fsps_pkg;

    // fixed field widths
    localparam int PIXEL_W    = 16;
    localparam int SUM_W      = 34;
    localparam int IDX_W      = 10;
    localparam int CFG_W      = 19;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register map (byte addresses)
    localparam logic [APB_ADDR_W-1:0] REG_PIXELS_PER_FRAME = 3'd0;

    // register reset value
    localparam logic [CFG_W-1:0] PIXELS_PER_FRAME_RST = 19'd262144;

    // input transaction
    typedef struct packed {
        logic signed [PIXEL_W-1:0] pixel;
        logic                      end_of_sequence;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic [IDX_W-1:0] frame_index;
        logic [SUM_W-1:0] frame_sad;
        logic [IDX_W-1:0] peak_index;
        logic [SUM_W-1:0] peak_sad;
        logic             last;
    } t_out_item;

    // per-pixel control handed to the accumulate stage
    typedef struct packed {
        logic use_ref;   // compare against stored reference
        logic done;      // pixel closes a frame
        logic eos;       // pixel closes the sequence
    } t_acc_ctl;

endpackage

`default_nettype wire

/* sv/fsps_sum_peak.sv */
// ----------------------------------------------------------------------------
// fsps_sum_peak: absolute difference, frame accumulation and peak tracking
// Takes one pixel with its reference per cycle unless stalled, adds the
// saturated absolute difference to the frame sum, emits a result at frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module fsps_sum_peak #(
    parameter int FRM_W = 10
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    input  fsps_pkg::t_acc_ctl               i_ctl,
    input  wire signed [fsps_pkg::PIXEL_W-1:0] i_pixel,
    input  wire signed [fsps_pkg::PIXEL_W-1:0] i_ref,
    input  wire [FRM_W-1:0]                  i_frame,
    output logic                             o_take,
    output logic                             o_out_valid,
    output fsps_pkg::t_out_item              o_out_data,
    input  wire                              i_out_stall
);

    localparam int PW = fsps_pkg::PIXEL_W;
    localparam int SW = fsps_pkg::SUM_W;

    logic [SW-1:0]        r_sum;
    logic [SW-1:0]        r_best_sum;
    logic [FRM_W-1:0]     r_best_frame;
    logic                 r_out_valid;
    fsps_pkg::t_out_item  r_out_data;

    logic signed [PW:0]   w_delta;
    logic [PW:0]          w_abs;
    logic [PW:0]          w_diff;
    logic [SW:0]          w_sum_wide;
    logic [SW-1:0]        w_sum;
    logic                 w_peak_hit;
    logic [SW-1:0]        w_best_sum;
    logic [FRM_W-1:0]     w_best_frame;

    // stage moves unless a frame result would overwrite a stalled result
    assign o_take = i_valid && !(i_ctl.done && r_out_valid && i_out_stall);

    // absolute difference against the reference pixel
    always_comb begin
        w_delta = {i_pixel[PW-1], i_pixel} - {i_ref[PW-1], i_ref};
        w_abs   = w_delta[PW] ? (PW+1)'(-w_delta) : w_delta;
        w_diff  = i_ctl.use_ref ? w_abs : '0;
    end

    // saturating accumulate and strict greater-than peak test
    always_comb begin
        w_sum_wide   = {1'b0, r_sum} + (SW+1)'(w_diff);
        w_sum        = w_sum_wide[SW] ? {SW{1'b1}} : w_sum_wide[SW-1:0];
        w_peak_hit   = w_sum > r_best_sum;
        w_best_sum   = w_peak_hit ? w_sum : r_best_sum;
        w_best_frame = w_peak_hit ? i_frame : r_best_frame;
    end

    // running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_best_sum   <= '0;
            r_best_frame <= '0;
        end else if (o_take) begin
            if (i_ctl.done && i_ctl.eos) begin
                r_sum        <= '0;
                r_best_sum   <= '0;
                r_best_frame <= '0;
            end else if (i_ctl.done) begin
                r_sum        <= '0;
                r_best_sum   <= w_best_sum;
                r_best_frame <= w_best_frame;
            end else begin
                r_sum <= w_sum;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && i_ctl.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_ctl.done) begin
            r_out_data.frame_index <= fsps_pkg::IDX_W'(i_frame);
            r_out_data.frame_sad   <= w_sum;
            r_out_data.peak_index  <= fsps_pkg::IDX_W'(w_best_frame);
            r_out_data.peak_sad    <= w_best_sum;
            r_out_data.last        <= i_ctl.eos;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

/* sv/frame_sad_peak_select.sv */
// ----------------------------------------------------------------------------
// frame_sad_peak_select: per-frame sum of absolute differences with peak pick
// Stores the first frame as reference and reports, for every frame, its sum
// of absolute differences against that reference and the running peak.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one signed
//   pixel per transaction in raster order, frame after frame; set
//   end_of_sequence on the final pixel to close the sequence and restart.
//   Output channel (o_out_valid / i_out_stall / o_out_data) carries one
//   transaction per completed frame: frame index, its sum, the peak so far
//   and a last flag.
//   The APB port holds pixels_per_frame at address 0; write it while idle.
//   Throughput: one pixel per cycle while no frame end meets a held result,
//   set by the single-port reference memory read plus one accumulate stage.
//   A frame result passes the stage one register, then the output register.
//   Receiver stall: pixels keep flowing until a frame end meets a held
//   result; only then is the input stalled.
//   Reset: counters, sums and peak clear; the reference memory is not
//   cleared, frame zero rewrites it.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_sad_peak_select #(
    parameter int MAX_PIXELS = 262144,
    parameter int MAX_FRAMES = 1024
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // pixel stream
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  fsps_pkg::t_in_item                  i_in_data,
    // frame results
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output fsps_pkg::t_out_item                 o_out_data,
    // configuration
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [fsps_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire [fsps_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [fsps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int PW    = fsps_pkg::PIXEL_W;
    localparam int CW    = fsps_pkg::CFG_W;
    localparam int POS_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int FRM_W = $clog2(MAX_FRAMES);
    localparam int LEN_A = $clog2(MAX_PIXELS + 1);
    localparam int LEN_W = (LEN_A > CW) ? LEN_A : CW;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PIXELS);
    localparam logic [FRM_W-1:0] FRM_MAX = FRM_W'(MAX_FRAMES - 1);

    logic [CW-1:0]           r_cfg_len;
    logic [POS_W-1:0]        r_pos;
    logic [FRM_W-1:0]        r_frame;
    logic signed [PW-1:0]    r_mem [MAX_PIXELS];
    logic signed [PW-1:0]    r_ref;

    logic                    r_s1_valid;
    fsps_pkg::t_acc_ctl      r_s1_ctl;
    logic signed [PW-1:0]    r_s1_pixel;
    logic [FRM_W-1:0]        r_s1_frame;

    logic                    w_cfg_wr;
    logic [LEN_W-1:0]        w_len_raw;
    logic [LEN_W-1:0]        w_len;
    logic [LEN_W-1:0]        w_pos_inc;
    logic                    w_frame_end;
    logic                    w_in_accept;
    logic                    w_take;

    // configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr == fsps_pkg::REG_PIXELS_PER_FRAME);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= fsps_pkg::PIXELS_PER_FRAME_RST;
        end else if (w_cfg_wr) begin
            r_cfg_len <= pwdata[CW-1:0];
        end
    end

    assign prdata = (paddr == fsps_pkg::REG_PIXELS_PER_FRAME)
                    ? fsps_pkg::APB_DATA_W'(r_cfg_len) : '0;

    // effective frame length and frame end detect
    always_comb begin
        w_len_raw = LEN_W'(r_cfg_len);
        if (w_len_raw == '0) begin
            w_len = LEN_W'(1);
        end else if (w_len_raw > LEN_MAX) begin
            w_len = LEN_MAX;
        end else begin
            w_len = w_len_raw;
        end
        w_pos_inc   = LEN_W'(r_pos) + LEN_W'(1);
        w_frame_end = i_in_data.end_of_sequence || !(w_pos_inc < w_len);
    end

    // input handshake
    assign o_in_stall  = r_s1_valid && !w_take;
    assign w_in_accept = i_in_valid && !o_in_stall;

    // position and frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_frame <= '0;
        end else if (w_in_accept) begin
            if (w_frame_end) begin
                r_pos <= '0;
                if (i_in_data.end_of_sequence) begin
                    r_frame <= '0;
                end else if (r_frame != FRM_MAX) begin
                    r_frame <= r_frame + 1'b1;
                end
            end else begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    // reference memory: frame zero writes, later frames read
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            if (r_frame == '0) begin
                r_mem[r_pos] <= i_in_data.pixel;
            end
            r_ref <= r_mem[r_pos];
        end
    end

    // stage one register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_ctl.use_ref <= (r_frame != '0);
            r_s1_ctl.done    <= w_frame_end;
            r_s1_ctl.eos     <= i_in_data.end_of_sequence;
            r_s1_pixel       <= i_in_data.pixel;
            r_s1_frame       <= r_frame;
        end
    end

    // accumulate, peak and output register
    fsps_sum_peak #(
        .FRM_W (FRM_W)
    ) u_sum_peak (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_valid),
        .i_ctl       (r_s1_ctl),
        .i_pixel     (r_s1_pixel),
        .i_ref       (r_ref),
        .i_frame     (r_s1_frame),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // checks
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && r_s1_ctl.done))
        else $error("input stalled without a held frame result");

    a_peak_ge_sad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.peak_sad >= o_out_data.frame_sad))
        else $error("peak sum below reported frame sum");

    a_frame_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frame == FRM_MAX) && w_in_accept && !i_in_data.end_of_sequence
        |=> (r_frame == FRM_MAX))
        else $error("frame counter left its saturation value");

    a_eos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept && i_in_data.end_of_sequence |=> (r_pos == '0) && (r_frame == '0))
        else $error("sequence end did not restart counters");

endmodule

`default_nettype wire

/* test/tb_frame_sad_peak_select.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_sad_peak_select: self-checking regression of the frame sad selector
// A directed table covers the pixel extremes, the peak tie rule, out-of-range
// frame lengths, a length change inside a frame and an early end of sequence.
// Random pixel sequences follow, including a frame counter saturation run.
// Every frame result is checked against a local model of the block or a table row.
// ----------------------------------------------------------------------------

module tb_frame_sad_peak_select;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 6;
    localparam int MAX_PIX       = 262144;
    localparam int MAX_FRM       = 1024;
    localparam int RANDOM_ITEMS  = 300;
    localparam int SAT_FRAMES    = 1030;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AT       = 25;
    localparam int QUIET_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 10;
    localparam logic [fsps_pkg::SUM_W-1:0]      SUM_MAX        = '1;
    localparam logic [fsps_pkg::APB_DATA_W-1:0] LEN_FIELD_MASK = 32'h7FFFF;

    typedef enum logic {ROW_PIXEL, ROW_CONFIG} t_row_kind;
    typedef enum logic [1:0] {FILL_RANDOM, FILL_EXTREME, FILL_REF, FILL_OFFSET} t_fill_mode;

    typedef struct {
        t_row_kind            kind;
        logic [31:0]          cfg_value;
        fsps_pkg::t_in_item   px;
        bit                   typed;
        fsps_pkg::t_out_item  res;
    } t_stim_row;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_stall;
    fsps_pkg::t_in_item                  i_in_data;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    fsps_pkg::t_out_item                 o_out_data;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [fsps_pkg::APB_ADDR_W-1:0]     paddr;
    logic [fsps_pkg::APB_DATA_W-1:0]     pwdata;
    logic [fsps_pkg::APB_DATA_W-1:0]     prdata;
    logic                                pready;

    // model state
    logic signed [fsps_pkg::PIXEL_W-1:0] ref_img [MAX_PIX];
    int unsigned                 ref_span   = 0;   // written reference entries form [0, ref_span)
    int unsigned                 px_pos     = 0;
    int unsigned                 frame_no   = 0;
    int unsigned                 peak_frame = 0;
    logic [fsps_pkg::SUM_W-1:0]  frame_acc  = '0;
    logic [fsps_pkg::SUM_W-1:0]  peak_acc   = '0;
    logic [fsps_pkg::CFG_W-1:0]  len_reg    = fsps_pkg::PIXELS_PER_FRAME_RST;

    fsps_pkg::t_out_item frame_results_q[$];   // expected frame results, oldest first
    t_stim_row           dir_tab[$];
    int        errors        = 0;
    int        items_sent    = 0;
    int        rx_count      = 0;
    int        rx_stall_left = 0;
    int        quiet_cycles  = 0;
    bit        hold_done     = 1'b0;
    bit        tx_idle_en    = 1'b1;
    bit        rx_idle_en    = 1'b1;

    frame_sad_peak_select DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // clock
    initial begin : clock_gen
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // effective frame length, register clamped to 1..MAX_PIX
    function automatic int unsigned frame_len();
        if (len_reg == '0) return 1;
        if (len_reg > MAX_PIX) return MAX_PIX;
        return 32'(len_reg);
    endfunction

    // advance the model by one pixel, returns 1 when a frame closes
    function automatic bit predict_frame_result(input fsps_pkg::t_in_item it,
            output fsps_pkg::t_out_item res);
        int unsigned                  len;
        int                           d;
        logic [fsps_pkg::SUM_W:0]     wide;
        len = frame_len();
        d   = 0;
        res = '0;
        if (px_pos < MAX_PIX) begin
            if (frame_no == 0) begin
                ref_img[px_pos] = it.pixel;
                if (px_pos >= ref_span) ref_span = px_pos + 1;
            end else begin
                d = $signed(it.pixel) - $signed(ref_img[px_pos]);
                if (d < 0) d = -d;
            end
        end
        // saturating frame sum
        wide      = {1'b0, frame_acc} + (fsps_pkg::SUM_W+1)'(d[16:0]);
        frame_acc = wide[fsps_pkg::SUM_W] ? SUM_MAX : wide[fsps_pkg::SUM_W-1:0];
        if (!it.end_of_sequence && px_pos + 1 < len) begin
            px_pos++;
            return 1'b0;
        end
        // strict greater-than peak update
        if (frame_acc > peak_acc) begin
            peak_acc   = frame_acc;
            peak_frame = frame_no;
        end
        res.frame_index = frame_no[fsps_pkg::IDX_W-1:0];
        res.frame_sad   = frame_acc;
        res.peak_index  = peak_frame[fsps_pkg::IDX_W-1:0];
        res.peak_sad    = peak_acc;
        res.last        = it.end_of_sequence;
        px_pos    = 0;
        frame_acc = '0;
        if (it.end_of_sequence) begin
            frame_no   = 0;
            peak_acc   = '0;
            peak_frame = 0;
        end else if (frame_no < MAX_FRM - 1) begin
            frame_no++;
        end
        return 1'b1;
    endfunction

    // directed table entry
    function automatic void add_row(t_row_kind kind, int value, bit eos, bit typed = 1'b0,
            int idx = 0, longint sad = 0, int pidx = 0, longint psad = 0, bit last = 1'b0);
        t_stim_row r;
        r.kind                 = kind;
        r.cfg_value            = value;
        r.px.pixel             = value[fsps_pkg::PIXEL_W-1:0];
        r.px.end_of_sequence   = eos;
        r.typed                = typed;
        r.res.frame_index      = idx[fsps_pkg::IDX_W-1:0];
        r.res.frame_sad        = sad[fsps_pkg::SUM_W-1:0];
        r.res.peak_index       = pidx[fsps_pkg::IDX_W-1:0];
        r.res.peak_sad         = psad[fsps_pkg::SUM_W-1:0];
        r.res.last             = last;
        dir_tab.insert(dir_tab.size(), r);
    endfunction

    // random pixel, optionally tied to the stored reference
    function automatic logic [fsps_pkg::PIXEL_W-1:0] next_pixel(t_fill_mode mode,
            logic [fsps_pkg::PIXEL_W-1:0] offset);
        if (frame_no != 0 && px_pos < ref_span) begin
            if (mode == FILL_REF) return ref_img[px_pos];
            if (mode == FILL_OFFSET) return ref_img[px_pos] + offset;
        end
        if (mode == FILL_EXTREME) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        return fsps_pkg::PIXEL_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // new frame length; inside a sequence never past the written reference
    function automatic logic [31:0] pick_length();
        if (frame_no != 0) return $urandom_range(0, ref_span);
        case ($urandom_range(0, 19))
            0: return 0;
            1: return MAX_PIX;
            2: return LEN_FIELD_MASK;
            3: return $urandom_range(MAX_PIX + 1, LEN_FIELD_MASK);
            4: return $urandom_range(65, MAX_PIX - 1);
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    // one pixel transaction, model updated on acceptance
    task automatic send_pixel(input logic [fsps_pkg::PIXEL_W-1:0] pix, input bit eos,
            input bit typed, input fsps_pkg::t_out_item typed_res);
        int                   gap;
        bit                   got;
        fsps_pkg::t_in_item   it;
        fsps_pkg::t_out_item  res;
        it.pixel           = pix;
        it.end_of_sequence = eos;
        gap = tx_idle_en ? $urandom_range(0, 5) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        got = predict_frame_result(it, res);
        if (typed) frame_results_q.insert(frame_results_q.size(), typed_res);
        else if (got) frame_results_q.insert(frame_results_q.size(), res);
        items_sent++;
    endtask

    // apb setup and access cycle
    task automatic apb_access(input bit wr, input logic [fsps_pkg::APB_DATA_W-1:0] wdata,
            output logic [fsps_pkg::APB_DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= fsps_pkg::REG_PIXELS_PER_FRAME;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // frame length write while idle, with read back
    task automatic set_frame_length(input logic [31:0] value);
        logic [fsps_pkg::APB_DATA_W-1:0] rd;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        apb_access(1'b1, value, rd);
        apb_access(1'b0, '0, rd);
        len_reg = value[fsps_pkg::CFG_W-1:0];
        if (rd !== (value & LEN_FIELD_MASK)) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("pixels_per_frame read back: expected %0d, got %0d",
                         value & LEN_FIELD_MASK, rd);
        end
    endtask

    // frame result check and receiver stall plan
    always @(posedge i_clk) begin : result_check
        fsps_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (frame_results_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected frame result: idx %0d sad %0d",
                             o_out_data.frame_index, o_out_data.frame_sad);
            end else begin
                want = frame_results_q.pop_front();
                if (o_out_data.frame_index !== want.frame_index ||
                    o_out_data.frame_sad !== want.frame_sad ||
                    o_out_data.peak_index !== want.peak_index ||
                    o_out_data.peak_sad !== want.peak_sad ||
                    o_out_data.last !== want.last) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display({"frame result mismatch: expected idx %0d sad %0d peak %0d/%0d",
                                  " last %0b, got idx %0d sad %0d peak %0d/%0d last %0b"},
                                 want.frame_index, want.frame_sad, want.peak_index,
                                 want.peak_sad, want.last, o_out_data.frame_index,
                                 o_out_data.frame_sad, o_out_data.peak_index,
                                 o_out_data.peak_sad, o_out_data.last);
                end
            end
            rx_count++;
            // one long hold so the block backs up into its input
            if (!hold_done && rx_count == HOLD_AT) begin
                rx_stall_left = LONG_HOLD;
                hold_done     = 1'b1;
            end else begin
                rx_stall_left = rx_idle_en ? $urandom_range(0, 5) : 0;
            end
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
        end
    end

    // receiver stall drive
    always @(negedge i_clk) begin : result_stall
        i_out_stall <= (rx_stall_left > 0);
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin : quiet_watch
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable && pready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("frame_sad_peak_select regression: fail");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    // stimulus
    initial begin : stimulus
        int                              base;
        int                              nframes;
        int                              left;
        bit                              eos;
        bit                              big;
        bit                              partial_tail;
        t_fill_mode                      mode;
        logic [fsps_pkg::PIXEL_W-1:0]    offset;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // full length after reset: pixel extremes, sequence closed early
        add_row(ROW_PIXEL, -32768, 1'b0);
        add_row(ROW_PIXEL, 32767, 1'b1, 1'b1, 0, 0, 0, 0, 1'b1);
        // zero length acts as one pixel per frame, tie keeps the older peak
        add_row(ROW_CONFIG, 0, 1'b0);
        add_row(ROW_PIXEL, 32767, 1'b0, 1'b1, 0, 0, 0, 0, 1'b0);
        add_row(ROW_PIXEL, -32768, 1'b0, 1'b1, 1, 65535, 1, 65535, 1'b0);
        add_row(ROW_PIXEL, 32767, 1'b0, 1'b1, 2, 0, 1, 65535, 1'b0);
        add_row(ROW_PIXEL, -32768, 1'b1, 1'b1, 3, 65535, 1, 65535, 1'b1);
        // four pixel frames
        add_row(ROW_CONFIG, 4, 1'b0);
        add_row(ROW_PIXEL, 0, 1'b0);
        add_row(ROW_PIXEL, -1, 1'b0);
        add_row(ROW_PIXEL, 100, 1'b0);
        add_row(ROW_PIXEL, -100, 1'b0);
        add_row(ROW_PIXEL, 1, 1'b0);
        add_row(ROW_PIXEL, -2, 1'b0);
        add_row(ROW_PIXEL, 32767, 1'b0);
        add_row(ROW_PIXEL, -32768, 1'b0);
        // shrink inside a frame already past the new length
        add_row(ROW_PIXEL, 5, 1'b0);
        add_row(ROW_PIXEL, -5, 1'b0);
        add_row(ROW_PIXEL, 12345, 1'b0);
        add_row(ROW_CONFIG, 2, 1'b0);
        add_row(ROW_PIXEL, -100, 1'b0);
        add_row(ROW_PIXEL, 7, 1'b0);
        add_row(ROW_PIXEL, 8, 1'b0);
        // end of sequence on the first pixel of a frame
        add_row(ROW_PIXEL, -7, 1'b1);
        // length field all ones clamps to the maximum
        add_row(ROW_CONFIG, 'h7FFFF, 1'b0);
        add_row(ROW_PIXEL, 1234, 1'b0);
        add_row(ROW_PIXEL, -1234, 1'b1, 1'b1, 0, 0, 0, 0, 1'b1);
        add_row(ROW_CONFIG, MAX_PIX, 1'b0);
        add_row(ROW_PIXEL, 21845, 1'b0);
        add_row(ROW_PIXEL, -21846, 1'b1, 1'b1, 0, 0, 0, 0, 1'b1);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CONFIG) set_frame_length(dir_tab[i].cfg_value);
            else send_pixel(dir_tab[i].px.pixel, dir_tab[i].px.end_of_sequence,
                            dir_tab[i].typed, dir_tab[i].res);
        end

        base = items_sent;
        // single pixel frames run the frame counter into saturation
        set_frame_length(1);
        mode   = FILL_RANDOM;
        offset = '0;
        for (int f = 0; f < SAT_FRAMES; f++) begin
            if (f % 150 == 0) begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
                mode       = t_fill_mode'($urandom_range(0, 3));
                offset     = fsps_pkg::PIXEL_W'($urandom_range(0, 16'hFFFF));
            end
            send_pixel(next_pixel(mode, offset), f == SAT_FRAMES - 1, 1'b0, '0);
        end

        // random sequences, phases may stop inside a frame
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) != 0) set_frame_length(pick_length());
            mode         = t_fill_mode'($urandom_range(0, 3));
            offset       = $urandom_range(0, 1)
                           ? fsps_pkg::PIXEL_W'($urandom_range(0, 16'hFFFF))
                           : fsps_pkg::PIXEL_W'($urandom_range(0, 3));
            nframes      = $urandom_range(1, 6);
            partial_tail = ($urandom_range(0, 2) == 0);
            eos          = 1'b0;
            for (int f = 0; f < nframes; f++) begin
                big  = frame_len() > 64;
                left = big ? $urandom_range(1, 8)
                           : (px_pos >= frame_len() ? 1 : frame_len() - px_pos);
                if (!big && f == nframes - 1 && partial_tail && left > 1)
                    left = $urandom_range(1, left - 1);
                for (int k = 0; k < left; k++) begin
                    eos = (k == left - 1) && (big || (f == nframes - 1 && !partial_tail));
                    // stray end of sequence anywhere
                    if ($urandom_range(0, 59) == 0) eos = 1'b1;
                    send_pixel(next_pixel(mode, offset), eos, 1'b0, '0);
                    if (eos) break;
                end
                if (eos) break;
            end
        end

        // drain
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge i_clk);
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && frame_results_q.size() == 0) begin
            $display("frame_sad_peak_select regression: pass");
        end else begin
            $display("frame_sad_peak_select regression: fail");
        end
        $finish;
    end

endmodule
